@@ rtl/bvm_pkg.sv @@
package bvm_pkg;

   localparam int DEPTH    = 16;
   localparam int RAW_W    = 12;
   localparam int CFG_W    = 14;
   localparam int PCT_W    = 7;
   localparam int RAW_MAX  = (1 << RAW_W) - 1;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W   = $clog2(DEPTH + 1);
   localparam int SUM_W    = $clog2(DEPTH * (RAW_MAX - 1) + 1);
   localparam int PROD_W   = RAW_W + CFG_W;
   localparam int DIV_W    = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int STEP_W   = $clog2(DIV_W);
   localparam int CSR_IDX_W = 3;

   // floor(p / RAW_MAX) = (p * MV_RECIP) >> MV_SHIFT for every p below 2**PROD_W
   localparam int MV_SHIFT = PROD_W + RAW_W;
   localparam int RECIP_W  = PROD_W + 1;
   localparam int RPROD_W  = DIV_W + RECIP_W;
   localparam longint unsigned MV_RECIP_VAL =
      ((64'd1 << MV_SHIFT) + 64'(RAW_MAX) - 64'd1) / 64'(RAW_MAX);
   localparam logic [RECIP_W-1:0] MV_RECIP = RECIP_W'(MV_RECIP_VAL);

   localparam logic [CFG_W-1:0] FULLSCALE_RST = CFG_W'(6600);
   localparam logic [CFG_W-1:0] FULL_RST      = CFG_W'(4200);
   localparam logic [CFG_W-1:0] EMPTY_RST     = CFG_W'(3000);
   localparam logic [CFG_W-1:0] VLOW_RST      = CFG_W'(2500);
   localparam logic [CFG_W-1:0] VHIGH_RST     = CFG_W'(4500);
   localparam logic [PCT_W-1:0] COMPLETE_RST  = PCT_W'(95);
   localparam logic [PCT_W-1:0] PCT_FULL      = PCT_W'(100);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULLSCALE = 3'd0,
      CSR_FULL      = 3'd1,
      CSR_EMPTY     = 3'd2,
      CSR_VLOW      = 3'd3,
      CSR_VHIGH     = 3'd4,
      CSR_COMPLETE  = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_CONNECTED    = 2'd1,
      EV_COMPLETE     = 2'd2,
      EV_DISCONNECTED = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_AVG,
      ST_MUL_MV,
      ST_RECIP_MV,
      ST_CHECK,
      ST_DIV_PCT,
      ST_FIN
   } state_type;

endpackage

@@ rtl/battery_voltage_monitor.sv @@
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | operation, charge_pin, raw_sample
// rsp     | out       | rsp_valid / rsp_ready  | charging, charge_event, voltage_mv,
//         |           |                        | percent, reading_ok
// csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
// One word at a time. A poll or rail word goes from accept to ST_FIN; a sample
// word passes ST_SUM, ST_DIV_AVG, ST_MUL_MV, ST_RECIP_MV, ST_CHECK and, if needed,
// ST_DIV_PCT first. The shared restoring divider gives one quotient bit per cycle
// (average, percent); millivolts come from a reciprocal multiply by 1/4095.
// Synchronous reset; the sample store uses per-entry valid bits, no clear pass.
// A stalled rsp holds the finished word in ST_FIN; req is taken again once the
// result register is loaded.
module battery_voltage_monitor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic                           req_charge_pin,
   input  logic [bvm_pkg::RAW_W-1:0]      req_raw_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_charging,
   output logic [1:0]                     rsp_charge_event,
   output logic [bvm_pkg::CFG_W-1:0]      rsp_voltage_mv,
   output logic [bvm_pkg::PCT_W-1:0]      rsp_percent,
   output logic                           rsp_reading_ok,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bvm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bvm_pkg::CFG_W-1:0]      csr_wdata
);

   // configuration
   logic [bvm_pkg::CFG_W-1:0] fullscale_ff, full_ff, empty_ff, vlow_ff, vhigh_ff;
   logic [bvm_pkg::PCT_W-1:0] complete_ff;

   // control and state
   bvm_pkg::state_type         state_ff, state_in;
   logic [bvm_pkg::DEPTH-1:0]  entry_vld_ff, entry_vld_in;
   logic [bvm_pkg::IDX_W-1:0]  ring_idx_ff, ring_idx_in;
   logic [bvm_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [bvm_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                       last_chg_ff, last_chg_in;
   logic [bvm_pkg::CFG_W-1:0]  held_mv_ff, held_mv_in;
   logic [bvm_pkg::PCT_W-1:0]  held_pct_ff, held_pct_in;
   logic                       valid_flag_ff, valid_flag_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // payload
   logic [bvm_pkg::RAW_W-1:0]  raw_ff, raw_in;
   logic                       chg_ff, chg_in;
   bvm_pkg::event_type         ev_ff, ev_in;
   logic [bvm_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [bvm_pkg::CFG_W-1:0]  rem_ff, rem_in;
   logic [bvm_pkg::CFG_W-1:0]  dvs_ff, dvs_in;
   logic [bvm_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       out_chg_ff;
   bvm_pkg::event_type         out_ev_ff;
   logic [bvm_pkg::CFG_W-1:0]  out_mv_ff;
   logic [bvm_pkg::PCT_W-1:0]  out_pct_ff;
   logic                       out_vld_ff;
   logic                       load_out;

   // sample store
   logic [bvm_pkg::RAW_W-1:0]  sample_mem [bvm_pkg::DEPTH];
   logic [bvm_pkg::RAW_W-1:0]  rd_data_ff;
   logic                       mem_we;

   // divider step
   logic [bvm_pkg::CFG_W:0]    rem_sh;
   logic                       step_ge;
   logic [bvm_pkg::CFG_W:0]    rem_sub;
   logic                       step_last;

   logic [bvm_pkg::RPROD_W-1:0] recip_prod;
   logic [bvm_pkg::RAW_W-1:0]  old_sample;
   logic [bvm_pkg::CFG_W-1:0]  mv;
   logic                       accept;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == bvm_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign rem_sh    = {rem_ff, quo_ff[bvm_pkg::DIV_W-1]};
   assign step_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub   = rem_sh - {1'b0, dvs_ff};
   assign step_last = (step_ff == bvm_pkg::STEP_W'(bvm_pkg::DIV_W - 1));
   assign old_sample = entry_vld_ff[ring_idx_ff] ? rd_data_ff : '0;
   assign mv        = quo_ff[bvm_pkg::CFG_W-1:0];
   assign recip_prod = bvm_pkg::RPROD_W'(quo_ff) * bvm_pkg::RPROD_W'(bvm_pkg::MV_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         fullscale_ff <= bvm_pkg::FULLSCALE_RST;
         full_ff      <= bvm_pkg::FULL_RST;
         empty_ff     <= bvm_pkg::EMPTY_RST;
         vlow_ff      <= bvm_pkg::VLOW_RST;
         vhigh_ff     <= bvm_pkg::VHIGH_RST;
         complete_ff  <= bvm_pkg::COMPLETE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (bvm_pkg::csr_reg_type'(csr_index))
            bvm_pkg::CSR_FULLSCALE: fullscale_ff <= csr_wdata;
            bvm_pkg::CSR_FULL:      full_ff      <= csr_wdata;
            bvm_pkg::CSR_EMPTY:     empty_ff     <= csr_wdata;
            bvm_pkg::CSR_VLOW:      vlow_ff      <= csr_wdata;
            bvm_pkg::CSR_VHIGH:     vhigh_ff     <= csr_wdata;
            bvm_pkg::CSR_COMPLETE:  complete_ff  <= csr_wdata[bvm_pkg::PCT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bvm_pkg::ST_IDLE;
         entry_vld_ff  <= '0;
         ring_idx_ff   <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         last_chg_ff   <= 1'b0;
         held_mv_ff    <= bvm_pkg::FULL_RST;
         held_pct_ff   <= bvm_pkg::PCT_FULL;
         valid_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         entry_vld_ff  <= entry_vld_in;
         ring_idx_ff   <= ring_idx_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         last_chg_ff   <= last_chg_in;
         held_mv_ff    <= held_mv_in;
         held_pct_ff   <= held_pct_in;
         valid_flag_ff <= valid_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      chg_ff  <= chg_in;
      ev_ff   <= ev_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (load_out) begin
         out_chg_ff <= chg_ff;
         out_ev_ff  <= ev_ff;
         out_mv_ff  <= held_mv_ff;
         out_pct_ff <= held_pct_ff;
         out_vld_ff <= valid_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= sample_mem[ring_idx_ff];
      if (mem_we) begin
         sample_mem[ring_idx_ff] <= raw_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      entry_vld_in  = entry_vld_ff;
      ring_idx_in   = ring_idx_ff;
      fill_in       = fill_ff;
      sum_in        = sum_ff;
      last_chg_in   = last_chg_ff;
      held_mv_in    = held_mv_ff;
      held_pct_in   = held_pct_ff;
      valid_flag_in = valid_flag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      raw_in        = raw_ff;
      chg_in        = chg_ff;
      ev_in         = ev_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      step_in       = step_ff;
      load_out      = 1'b0;
      mem_we        = 1'b0;

      unique case (state_ff)
         bvm_pkg::ST_IDLE: begin
            if (accept) begin
               raw_in = req_raw_sample;
               chg_in = !req_charge_pin;
               ev_in  = bvm_pkg::EV_NONE;
               if (!req_charge_pin != last_chg_ff) begin
                  if (!req_charge_pin) begin
                     ev_in = bvm_pkg::EV_CONNECTED;
                  end else if (held_pct_ff >= complete_ff) begin
                     ev_in = bvm_pkg::EV_COMPLETE;
                  end else begin
                     ev_in = bvm_pkg::EV_DISCONNECTED;
                  end
                  last_chg_in = !req_charge_pin;
               end
               if (!req_operation) begin
                  state_in = bvm_pkg::ST_FIN;
               end else if (req_raw_sample == '0 || req_raw_sample == '1) begin
                  valid_flag_in = 1'b0;
                  state_in      = bvm_pkg::ST_FIN;
               end else begin
                  state_in = bvm_pkg::ST_SUM;
               end
            end
         end
         bvm_pkg::ST_SUM: begin
            mem_we = 1'b1;
            entry_vld_in[ring_idx_ff] = 1'b1;
            sum_in = sum_ff - bvm_pkg::SUM_W'(old_sample) + bvm_pkg::SUM_W'(raw_ff);
            ring_idx_in = (ring_idx_ff == bvm_pkg::IDX_W'(bvm_pkg::DEPTH - 1)) ?
                          '0 : ring_idx_ff + 1'b1;
            if (fill_ff != bvm_pkg::FILL_W'(bvm_pkg::DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            quo_in   = bvm_pkg::DIV_W'(sum_in);
            dvs_in   = bvm_pkg::CFG_W'(fill_in);
            rem_in   = '0;
            step_in  = '0;
            state_in = bvm_pkg::ST_DIV_AVG;
         end
         bvm_pkg::ST_DIV_AVG, bvm_pkg::ST_DIV_PCT: begin
            rem_in  = step_ge ? rem_sub[bvm_pkg::CFG_W-1:0] : rem_sh[bvm_pkg::CFG_W-1:0];
            quo_in  = {quo_ff[bvm_pkg::DIV_W-2:0], step_ge};
            step_in = step_ff + 1'b1;
            if (step_last) begin
               if (state_ff == bvm_pkg::ST_DIV_AVG) begin
                  state_in = bvm_pkg::ST_MUL_MV;
               end else begin
                  held_pct_in = quo_in[bvm_pkg::PCT_W-1:0];
                  state_in    = bvm_pkg::ST_FIN;
               end
            end
         end
         bvm_pkg::ST_MUL_MV: begin
            quo_in   = bvm_pkg::DIV_W'(quo_ff[bvm_pkg::RAW_W-1:0]) *
                       bvm_pkg::DIV_W'(fullscale_ff);
            state_in = bvm_pkg::ST_RECIP_MV;
         end
         bvm_pkg::ST_RECIP_MV: begin
            quo_in   = bvm_pkg::DIV_W'(recip_prod[bvm_pkg::RPROD_W-1:bvm_pkg::MV_SHIFT]);
            state_in = bvm_pkg::ST_CHECK;
         end
         bvm_pkg::ST_CHECK: begin
            if (mv > vlow_ff && mv < vhigh_ff) begin
               held_mv_in    = mv;
               valid_flag_in = 1'b1;
               if (mv >= full_ff) begin
                  held_pct_in = bvm_pkg::PCT_FULL;
                  state_in    = bvm_pkg::ST_FIN;
               end else if (mv <= empty_ff) begin
                  held_pct_in = '0;
                  state_in    = bvm_pkg::ST_FIN;
               end else begin
                  quo_in   = bvm_pkg::DIV_W'(mv - empty_ff) *
                             bvm_pkg::DIV_W'(bvm_pkg::PCT_FULL);
                  dvs_in   = full_ff - empty_ff;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = bvm_pkg::ST_DIV_PCT;
               end
            end else begin
               valid_flag_in = 1'b0;
               state_in      = bvm_pkg::ST_FIN;
            end
         end
         bvm_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bvm_pkg::ST_IDLE;
            end
         end
         default: state_in = bvm_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_charging      = out_chg_ff;
   assign rsp_charge_event  = out_ev_ff;
   assign rsp_voltage_mv    = out_mv_ff;
   assign rsp_percent       = out_pct_ff;
   assign rsp_reading_ok    = out_vld_ff;

endmodule

@@ bench/testbench.sv @@
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bvm_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [bvm_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                       charging;
      bvm_pkg::event_type         charge_event;
      logic [bvm_pkg::CFG_W-1:0]  voltage_mv;
      logic [bvm_pkg::PCT_W-1:0]  percent;
      logic                       reading_ok;
   } gauge_word_type;

   typedef struct {
      logic                       op;
      logic                       pin;
      logic [bvm_pkg::RAW_W-1:0]  raw;
      logic                       typed;
      gauge_word_type             want;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_operation = 1'b0;
   logic                       req_charge_pin = 1'b1;
   logic [bvm_pkg::RAW_W-1:0]  req_raw_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_charging;
   logic [1:0]                 rsp_charge_event;
   logic [bvm_pkg::CFG_W-1:0]  rsp_voltage_mv;
   logic [bvm_pkg::PCT_W-1:0]  rsp_percent;
   logic                       rsp_reading_ok;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [bvm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bvm_pkg::CFG_W-1:0]  csr_wdata = '0;

   // gauge predictor: configuration copy and state
   int unsigned cfg_fullscale = 6600;
   int unsigned cfg_full      = 4200;
   int unsigned cfg_empty     = 3000;
   int unsigned cfg_vlow      = 2500;
   int unsigned cfg_vhigh     = 4500;
   int unsigned cfg_complete  = 95;
   int unsigned ring [bvm_pkg::DEPTH];
   int unsigned ring_slot = 0;
   int unsigned ring_fill = 0;
   int unsigned ring_sum  = 0;
   logic        chg_seen  = 1'b0;
   int unsigned held_mv   = 4200;
   int unsigned held_pct  = 100;
   logic        live      = 1'b0;

   gauge_word_type gauge_expect [$];
   logic        no_gaps   = 1'b0;
   logic        pin_level = 1'b1;
   int          errors = 0;
   int          words_sent = 0;
   int          results_checked = 0;
   int          events_seen = 0;
   int          valid_seen = 0;
   int          settings_done = 0;

   dir_row_type dir_rows [0:20] = '{
      '{1'b0, 1'b1, 12'd0,    1'b1,
        '{1'b0, bvm_pkg::EV_NONE,      14'd4200, 7'd100, 1'b0}},
      '{1'b0, 1'b0, 12'hFFF,  1'b1,
        '{1'b1, bvm_pkg::EV_CONNECTED, 14'd4200, 7'd100, 1'b0}},
      '{1'b1, 1'b0, 12'd0,    1'b1,
        '{1'b1, bvm_pkg::EV_NONE,      14'd4200, 7'd100, 1'b0}},
      '{1'b1, 1'b1, 12'd4095, 1'b1,
        '{1'b0, bvm_pkg::EV_COMPLETE,  14'd4200, 7'd100, 1'b0}},
      '{1'b1, 1'b1, 12'd1,    1'b1,
        '{1'b0, bvm_pkg::EV_NONE,      14'd4200, 7'd100, 1'b0}},
      '{1'b1, 1'b1, 12'd4094, 1'b0, '0},
      '{1'b1, 1'b0, 12'd2000, 1'b0, '0},
      '{1'b1, 1'b0, 12'd2600, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b1, 1'b0, 12'd1800, 1'b0, '0},
      '{1'b0, 1'b1, 12'd2730, 1'b0, '0},
      '{1'b1, 1'b0, 12'd2048, 1'b0, '0},
      '{1'b0, 1'b0, 12'hA5A,  1'b0, '0}
   };

   battery_voltage_monitor DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_charge_pin    (req_charge_pin),
      .req_raw_sample    (req_raw_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_charging      (rsp_charging),
      .rsp_charge_event  (rsp_charge_event),
      .rsp_voltage_mv    (rsp_voltage_mv),
      .rsp_percent       (rsp_percent),
      .rsp_reading_ok    (rsp_reading_ok),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic gauge_word_type predict_gauge(input logic op, input logic pin,
                                                    input logic [bvm_pkg::RAW_W-1:0] raw);
      gauge_word_type w;
      logic        now_chg;
      int unsigned avg;
      int unsigned mv;
      now_chg = !pin;
      w.charge_event = bvm_pkg::EV_NONE;
      if (now_chg != chg_seen) begin
         if (now_chg)
            w.charge_event = bvm_pkg::EV_CONNECTED;
         else if (held_pct >= cfg_complete)
            w.charge_event = bvm_pkg::EV_COMPLETE;
         else
            w.charge_event = bvm_pkg::EV_DISCONNECTED;
         chg_seen = now_chg;
      end
      if (op) begin
         if (raw == '0 || raw == '1) begin
            live = 1'b0;
         end else begin
            ring_sum = ring_sum - ring[ring_slot] + 32'(raw);
            ring[ring_slot] = 32'(raw);
            ring_slot = (ring_slot + 1) % bvm_pkg::DEPTH;
            if (ring_fill < bvm_pkg::DEPTH)
               ring_fill++;
            avg = ring_sum / ring_fill;
            mv = avg * cfg_fullscale / bvm_pkg::RAW_MAX;
            if (mv > cfg_vlow && mv < cfg_vhigh) begin
               held_mv = mv & 32'h3FFF;
               if (mv >= cfg_full)
                  held_pct = 100;
               else if (mv <= cfg_empty)
                  held_pct = 0;
               else
                  held_pct = (mv - cfg_empty) * 100 / (cfg_full - cfg_empty);
               live = 1'b1;
            end else begin
               live = 1'b0;
            end
         end
      end
      w.charging = now_chg;
      w.voltage_mv = bvm_pkg::CFG_W'(held_mv);
      w.percent = bvm_pkg::PCT_W'(held_pct);
      w.reading_ok = live;
      return w;
   endfunction

   task automatic send_word(input logic op, input logic pin,
                            input logic [bvm_pkg::RAW_W-1:0] raw,
                            input logic typed, input gauge_word_type fixed_w);
      gauge_word_type w;
      if (!no_gaps && $urandom_range(0, 99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_charge_pin <= pin;
      req_raw_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      w = predict_gauge(op, pin, raw);
      gauge_expect.push_back(typed ? fixed_w : w);
      words_sent++;
   endtask

   task automatic drain_gauge();
      req_valid <= 1'b0;
      while (gauge_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bvm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bvm_pkg::CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bvm_pkg::CSR_FULLSCALE: cfg_fullscale = 32'(data);
         bvm_pkg::CSR_FULL:      cfg_full = 32'(data);
         bvm_pkg::CSR_EMPTY:     cfg_empty = 32'(data);
         bvm_pkg::CSR_VLOW:      cfg_vlow = 32'(data);
         bvm_pkg::CSR_VHIGH:     cfg_vhigh = 32'(data);
         bvm_pkg::CSR_COMPLETE:  cfg_complete = 32'(data[bvm_pkg::PCT_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic program_gauge(input logic [bvm_pkg::CFG_W-1:0] fs,
                                input logic [bvm_pkg::CFG_W-1:0] full,
                                input logic [bvm_pkg::CFG_W-1:0] empty,
                                input logic [bvm_pkg::CFG_W-1:0] vlow,
                                input logic [bvm_pkg::CFG_W-1:0] vhigh,
                                input logic [bvm_pkg::CFG_W-1:0] complete);
      drain_gauge();
      write_csr(bvm_pkg::CSR_FULLSCALE, fs);
      write_csr(bvm_pkg::CSR_FULL, full);
      write_csr(bvm_pkg::CSR_EMPTY, empty);
      write_csr(CSR_SPARE_LO, bvm_pkg::CFG_W'($urandom));
      write_csr(bvm_pkg::CSR_VLOW, vlow);
      write_csr(bvm_pkg::CSR_VHIGH, vhigh);
      write_csr(CSR_SPARE_HI, bvm_pkg::CFG_W'($urandom));
      write_csr(bvm_pkg::CSR_COMPLETE, complete);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   task automatic run_random(input int count, input bit hold_mid);
      int          center;
      int          lo_raw;
      int          hi_raw;
      int          aim;
      int          raw_i;
      int          pick;
      logic        op;
      logic [bvm_pkg::RAW_W-1:0] raw;
      if (cfg_fullscale == 0) begin
         center = 2048;
         lo_raw = 1;
         hi_raw = bvm_pkg::RAW_MAX - 1;
      end else begin
         center = (cfg_vlow + cfg_vhigh) / 2 * bvm_pkg::RAW_MAX / cfg_fullscale;
         lo_raw = cfg_vlow * bvm_pkg::RAW_MAX / cfg_fullscale;
         hi_raw = cfg_vhigh * bvm_pkg::RAW_MAX / cfg_fullscale;
      end
      aim = center;
      for (int i = 0; i < count; i++) begin
         // hold the aim for a while so the filter settles on it
         if (i % 24 == 0) begin
            pick = $urandom_range(0, 3);
            aim = (pick == 0) ? lo_raw : (pick == 1) ? hi_raw :
                  center + int'($urandom_range(0, 120)) - 60;
         end
         if ($urandom_range(0, 99) < 8)
            pin_level = !pin_level;
         pick = $urandom_range(0, 99);
         op = (pick >= 10);
         if (pick < 10 || (pick >= 15 && pick < 27)) begin
            raw = bvm_pkg::RAW_W'($urandom_range(0, bvm_pkg::RAW_MAX));
         end else if (pick < 15) begin
            raw = $urandom_range(0, 1) ? bvm_pkg::RAW_W'(bvm_pkg::RAW_MAX) : '0;
         end else begin
            raw_i = aim + (($urandom_range(0, 99) < 40) ? 0 : int'($urandom_range(0, 8)) - 4);
            raw_i = (raw_i < 1) ? 1 :
                    (raw_i > bvm_pkg::RAW_MAX - 1) ? bvm_pkg::RAW_MAX - 1 : raw_i;
            raw = bvm_pkg::RAW_W'(raw_i);
         end
         send_word(op, pin_level, raw, 1'b0, '0);
         if (hold_mid && i == count / 2)
            drain_gauge();
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 28);
   end

   always @(posedge clock) begin : check_gauge
      gauge_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (gauge_expect.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            errors++;
         end else begin
            want = gauge_expect.pop_front();
            if (rsp_charging !== want.charging) begin
               $display("%0t: charging expected %0d got %0d", $time, want.charging,
                        rsp_charging);
               errors++;
            end
            if (rsp_charge_event !== want.charge_event) begin
               $display("%0t: charge_event expected %0d got %0d", $time, want.charge_event,
                        rsp_charge_event);
               errors++;
            end
            if (rsp_voltage_mv !== want.voltage_mv) begin
               $display("%0t: voltage_mv expected %0d got %0d", $time, want.voltage_mv,
                        rsp_voltage_mv);
               errors++;
            end
            if (rsp_percent !== want.percent) begin
               $display("%0t: percent expected %0d got %0d", $time, want.percent,
                        rsp_percent);
               errors++;
            end
            if (rsp_reading_ok !== want.reading_ok) begin
               $display("%0t: reading_ok expected %0d got %0d", $time,
                        want.reading_ok, rsp_reading_ok);
               errors++;
            end
            if (rsp_charge_event != bvm_pkg::EV_NONE)
               events_seen++;
            if (rsp_reading_ok)
               valid_seen++;
            results_checked++;
         end
      end
   end

   initial begin
      for (int i = 0; i < bvm_pkg::DEPTH; i++)
         ring[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         pin_level = dir_rows[i].pin;
         send_word(dir_rows[i].op, dir_rows[i].pin, dir_rows[i].raw, dir_rows[i].typed,
                   dir_rows[i].want);
      end
      run_random(80, 1'b1);

      // narrow window, one raw step per millivolt, no idling on either side
      program_gauge(14'd4095, 14'd2100, 14'd2000, 14'd2000, 14'd2100, 14'd50);
      no_gaps = 1'b1;
      run_random(90, 1'b0);
      no_gaps = 1'b0;

      // full not above empty; complete written with upper bits set
      program_gauge(14'd16383, 14'd0, 14'd16383, 14'd0, 14'd16383, 14'h3F80);
      run_random(90, 1'b0);

      program_gauge(14'd0, 14'd16383, 14'd0, 14'd0, 14'd1, 14'd100);
      run_random(60, 1'b0);

      // threshold above 100
      program_gauge(14'd6600, 14'd4000, 14'd3000, 14'd0, 14'd16383, 14'd127);
      run_random(90, 1'b0);

      repeat (2) begin
         logic [bvm_pkg::CFG_W-1:0] empty;
         logic [bvm_pkg::CFG_W-1:0] full;
         empty = bvm_pkg::CFG_W'($urandom_range(0, 8000));
         full = empty + bvm_pkg::CFG_W'($urandom_range(0, 4000));
         program_gauge(bvm_pkg::CFG_W'($urandom_range(3000, 16383)), full, empty,
                       bvm_pkg::CFG_W'($urandom_range(0, empty)),
                       full + bvm_pkg::CFG_W'($urandom_range(1, 2000)),
                       bvm_pkg::CFG_W'($urandom_range(0, 100)));
         run_random(90, 1'b0);
      end

      program_gauge(bvm_pkg::FULLSCALE_RST, bvm_pkg::FULL_RST, bvm_pkg::EMPTY_RST,
                    bvm_pkg::VLOW_RST, bvm_pkg::VHIGH_RST,
                    bvm_pkg::CFG_W'(bvm_pkg::COMPLETE_RST));
      run_random(60, 1'b0);

      drain_gauge();
      repeat (20) @(posedge clock);
      $display("covered %0d words over %0d register settings: %0d results checked,",
               words_sent, settings_done + 1, results_checked);
      $display("  %0d charger events, %0d results with a good reading", events_seen,
               valid_seen);
      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
